FILE: rtl/elgamal_encrypt_decrypt_defines.svh
// Assertion macros shared by the ElGamal engine top level.
// No dependencies.
`ifndef ELGAMAL_ENCRYPT_DECRYPT_DEFINES_SVH
`define ELGAMAL_ENCRYPT_DECRYPT_DEFINES_SVH

`define EG_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

`define EG_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

FILE: rtl/elg_pkg.sv
// Types and constants for the ElGamal engine.
// No dependencies.
`timescale 1ns / 1ps
package elg_pkg;
  typedef enum logic [1:0] {
    REG_MODULUS     = 2'd0,
    REG_GENERATOR   = 2'd1,
    REG_PUBLIC_KEY  = 2'd2,
    REG_PRIVATE_KEY = 2'd3
  } reg_idx_t;

  typedef enum logic {
    ACT_ENCRYPT = 1'b0,
    ACT_DECRYPT = 1'b1
  } action_t;

  typedef struct packed {
    logic        action;
    logic [31:0] ephemeral_exponent;
    logic [31:0] message;
    logic [31:0] cipher_first;
    logic [31:0] cipher_second;
  } in_word_t;

  typedef struct packed {
    logic [31:0] first_value;
    logic [31:0] second_value;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_RED_C,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_POW_NEXT,
    ST_STEP_DONE,
    ST_FINAL_MUL,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] rem;
  } mod_rsp_t;
endpackage

FILE: rtl/elg_modmul.sv
// Shared modular unit: one 32 by MOD_WIDTH product, then a restoring remainder
// by the modulus, one bit per cycle. Depends on elg_pkg.
`timescale 1ns / 1ps
module elg_modmul #(
  parameter int unsigned MOD_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [31:0]          op_a,
  input  logic [MOD_WIDTH-1:0] op_b,
  input  logic [MOD_WIDTH-1:0] modulus,
  output elg_pkg::mod_rsp_t    rsp
);
  localparam int unsigned ProdW = 32 + MOD_WIDTH;
  localparam int unsigned CntW = $clog2(ProdW + 2);

  logic [ProdW-1:0]     prod_r, prod_nxt;
  logic [MOD_WIDTH:0]   rem_r, rem_nxt;
  logic [CntW-1:0]      cnt_r, cnt_nxt;
  logic                 mul_r, mul_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [MOD_WIDTH:0]   shifted;
  logic [MOD_WIDTH+1:0] diff;

  always_comb begin
    shifted = {rem_r[MOD_WIDTH-1:0], prod_r[ProdW-1]};
    diff = {1'b0, shifted} - {2'b00, modulus};
    prod_nxt = prod_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    mul_nxt = mul_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      mul_nxt = 1'b1;
      busy_nxt = 1'b1;
      prod_nxt = ProdW'(op_a) * ProdW'(op_b);
      rem_nxt = '0;
      cnt_nxt = CntW'(ProdW);
    end else if (mul_r) begin
      mul_nxt = 1'b0;
    end else if (busy_r) begin
      prod_nxt = {prod_r[ProdW-2:0], 1'b0};
      if (!diff[MOD_WIDTH+1]) begin
        rem_nxt = diff[MOD_WIDTH:0];
      end else begin
        rem_nxt = shifted;
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      mul_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      mul_r <= mul_nxt;
      cnt_r <= cnt_nxt;
    end
    prod_r <= prod_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.busy = busy_r | mul_r;
  assign rsp.done = done_r;
  assign rsp.rem = 32'(rem_r[MOD_WIDTH-1:0]);
endmodule

FILE: rtl/elg_seq.sv
// Sequencer: runs the powers and products of one word on the shared unit.
// Depends on elg_pkg and elg_modmul.
`timescale 1ns / 1ps
module elg_seq #(
  parameter int unsigned MOD_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  elg_pkg::in_word_t    item,
  input  logic [MOD_WIDTH-1:0] modulus,
  input  logic [31:0]          generator,
  input  logic [31:0]          public_key,
  input  logic [31:0]          private_key,
  output logic                 idle,
  output logic                 fin,
  output elg_pkg::out_word_t   result
);
  localparam int unsigned ExpCntW = 6;

  elg_pkg::seq_state_t state_r, state_nxt;
  logic [MOD_WIDTH-1:0] acc_r, acc_nxt, base_r, base_nxt;
  logic [31:0]          ta_r, ta_nxt, tb_r, tb_nxt, tc_r, tc_nxt;
  logic [31:0]          exp_r, exp_nxt;
  logic [ExpCntW-1:0]   ecnt_r, ecnt_nxt;
  logic [1:0]           step_r, step_nxt;
  logic                 act_r, act_nxt;
  logic [31:0]          r_r, r_nxt;
  logic [31:0]          first_r, first_nxt, second_r, second_nxt;
  logic                 start;
  logic [31:0]          op_a;
  logic [MOD_WIDTH-1:0] op_b;
  elg_pkg::mod_rsp_t    rsp;
  logic [MOD_WIDTH-1:0] one;
  logic [MOD_WIDTH-1:0] rem_w;

  assign one = (modulus == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
  assign rem_w = rsp.rem[MOD_WIDTH-1:0];

  elg_modmul #(.MOD_WIDTH(MOD_WIDTH)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(start), .op_a(op_a), .op_b(op_b),
    .modulus(modulus), .rsp(rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= elg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    acc_r <= acc_nxt; base_r <= base_nxt; ta_r <= ta_nxt; tb_r <= tb_nxt;
    tc_r <= tc_nxt; exp_r <= exp_nxt; ecnt_r <= ecnt_nxt; step_r <= step_nxt;
    act_r <= act_nxt; r_r <= r_nxt; first_r <= first_nxt; second_r <= second_nxt;
  end

  // Operands wider than the modulus are first reduced as value * 1.
  always_comb begin
    state_nxt = state_r;
    acc_nxt = acc_r; base_nxt = base_r; ta_nxt = ta_r; tb_nxt = tb_r;
    tc_nxt = tc_r; exp_nxt = exp_r; ecnt_nxt = ecnt_r; step_nxt = step_r;
    act_nxt = act_r; r_nxt = r_r; first_nxt = first_r; second_nxt = second_r;
    start = 1'b0;
    op_a = '0;
    op_b = one;
    fin = 1'b0;
    case (state_r)
      elg_pkg::ST_IDLE: begin
        if (go) begin
          act_nxt = item.action;
          r_nxt = item.ephemeral_exponent;
          first_nxt = '0;
          second_nxt = '0;
          if (modulus < MOD_WIDTH'(2)) begin
            state_nxt = elg_pkg::ST_OUT;
          end else if (item.action == elg_pkg::ACT_ENCRYPT) begin
            ta_nxt = generator;
            tb_nxt = public_key;
            tc_nxt = item.message;
            state_nxt = elg_pkg::ST_RED_A;
            start = 1'b1;
            op_a = generator;
          end else begin
            ta_nxt = item.cipher_first;
            tc_nxt = item.cipher_second;
            state_nxt = elg_pkg::ST_RED_A;
            start = 1'b1;
            op_a = item.cipher_first;
          end
        end
      end
      elg_pkg::ST_RED_A: begin
        if (rsp.done) begin
          ta_nxt = 32'(rem_w);
          state_nxt = elg_pkg::ST_RED_B;
          start = 1'b1;
          op_a = tc_r;
        end
      end
      elg_pkg::ST_RED_B: begin
        if (rsp.done) begin
          tc_nxt = 32'(rem_w);
          if (act_r == elg_pkg::ACT_ENCRYPT) begin
            state_nxt = elg_pkg::ST_RED_C;
            start = 1'b1;
            op_a = tb_r;
          end else begin
            base_nxt = MOD_WIDTH'(ta_r);
            acc_nxt = one;
            exp_nxt = private_key;
            ecnt_nxt = ExpCntW'(32);
            step_nxt = 2'd0;
            state_nxt = elg_pkg::ST_POW_MUL;
          end
        end
      end
      elg_pkg::ST_RED_C: begin
        if (rsp.done) begin
          tb_nxt = 32'(rem_w);
          base_nxt = MOD_WIDTH'(ta_r);
          acc_nxt = one;
          exp_nxt = r_r;
          ecnt_nxt = ExpCntW'(32);
          step_nxt = 2'd0;
          state_nxt = elg_pkg::ST_POW_MUL;
        end
      end
      elg_pkg::ST_POW_MUL: begin
        if (ecnt_r == '0) begin
          state_nxt = elg_pkg::ST_STEP_DONE;
        end else if (exp_r[0]) begin
          start = 1'b1;
          op_a = 32'(acc_r);
          op_b = base_r;
          state_nxt = elg_pkg::ST_POW_SQR;
        end else begin
          start = 1'b1;
          op_a = 32'(base_r);
          op_b = base_r;
          state_nxt = elg_pkg::ST_POW_NEXT;
        end
      end
      elg_pkg::ST_POW_SQR: begin
        if (rsp.done) begin
          acc_nxt = rem_w;
          start = 1'b1;
          op_a = 32'(base_r);
          op_b = base_r;
          state_nxt = elg_pkg::ST_POW_NEXT;
        end
      end
      elg_pkg::ST_POW_NEXT: begin
        if (rsp.done) begin
          base_nxt = rem_w;
          exp_nxt = {1'b0, exp_r[31:1]};
          ecnt_nxt = ecnt_r - 1'b1;
          state_nxt = elg_pkg::ST_POW_MUL;
        end
      end
      elg_pkg::ST_STEP_DONE: begin
        step_nxt = step_r + 2'd1;
        ecnt_nxt = ExpCntW'(32);
        acc_nxt = one;
        state_nxt = elg_pkg::ST_POW_MUL;
        if (act_r == elg_pkg::ACT_ENCRYPT) begin
          if (step_r == 2'd0) begin
            first_nxt = 32'(acc_r);
            base_nxt = MOD_WIDTH'(tb_r);
            exp_nxt = r_r;
          end else begin
            start = 1'b1;
            op_a = 32'(acc_r);
            op_b = MOD_WIDTH'(tc_r);
            state_nxt = elg_pkg::ST_FINAL_MUL;
          end
        end else begin
          if (step_r == 2'd0) begin
            base_nxt = acc_r;
            exp_nxt = 32'(modulus - MOD_WIDTH'(2));
          end else begin
            start = 1'b1;
            op_a = tc_r;
            op_b = acc_r;
            state_nxt = elg_pkg::ST_FINAL_MUL;
          end
        end
      end
      elg_pkg::ST_FINAL_MUL: begin
        if (rsp.done) begin
          if (act_r == elg_pkg::ACT_ENCRYPT) begin
            second_nxt = 32'(rem_w);
          end else begin
            first_nxt = 32'(rem_w);
          end
          state_nxt = elg_pkg::ST_OUT;
        end
      end
      elg_pkg::ST_OUT: begin
        fin = 1'b1;
        state_nxt = elg_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = elg_pkg::ST_IDLE;
      end
    endcase
  end

  assign idle = (state_r == elg_pkg::ST_IDLE);
  assign result.first_value = first_r;
  assign result.second_value = second_r;
endmodule

FILE: rtl/elgamal_encrypt_decrypt.sv
// ElGamal engine over a configurable modulus of up to MOD_WIDTH bits. An encrypt
// word gives (g^r, y^r*m) mod p; a decrypt word gives c2*(c1^a)^(p-2) mod p.
// All arithmetic goes through one shared multiply and bit-serial remainder unit.
// Each power scans all 32 exponent bits with one or two products per bit, and the
// engine works on one word at a time; a modulus below two gives zeros. The next
// word is taken once the previous result has been accepted, or in the same cycle.
// Depends on elg_pkg, elg_seq, elg_modmul and the defines header.
`timescale 1ns / 1ps
`include "elgamal_encrypt_decrypt_defines.svh"
module elgamal_encrypt_decrypt #(
  parameter int unsigned MOD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  elg_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output elg_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  logic [MOD_WIDTH-1:0] modulus_r;
  logic [31:0]          generator_r, public_key_r, private_key_r;
  logic                 seq_idle, seq_fin, go;
  elg_pkg::out_word_t   seq_res;
  elg_pkg::out_word_t   out_r;
  logic                 out_valid_r;
  logic                 busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_WIDTH'(32'd2147483647);
      generator_r <= 32'd7;
      public_key_r <= 32'd1;
      private_key_r <= 32'd1;
    end else if (cfg_we) begin
      case (elg_pkg::reg_idx_t'(cfg_index))
        elg_pkg::REG_MODULUS:     modulus_r <= cfg_wdata[MOD_WIDTH-1:0];
        elg_pkg::REG_GENERATOR:   generator_r <= cfg_wdata;
        elg_pkg::REG_PUBLIC_KEY:  public_key_r <= cfg_wdata;
        elg_pkg::REG_PRIVATE_KEY: private_key_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // A new word may start once the previous result has left the sequencer;
  // it holds in out_r until taken, and the next finish waits for that.
  assign in_ready = seq_idle && !busy_r && !(out_valid_r && !out_ready);
  assign go = in_valid && in_ready;

  elg_seq #(.MOD_WIDTH(MOD_WIDTH)) u_seq (
    .clk(clk), .rst_n(rst_n), .go(go), .item(in_data), .modulus(modulus_r),
    .generator(generator_r), .public_key(public_key_r),
    .private_key(private_key_r), .idle(seq_idle), .fin(seq_fin),
    .result(seq_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r <= 1'b0;
    end else begin
      if (seq_fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      busy_r <= 1'b0;
    end
    if (seq_fin) begin
      out_r <= seq_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  `EG_ASSERT_IMPL(a_go_idle, go, seq_idle)
  `EG_ASSERT_IMPL(a_fin_free, seq_fin, !out_valid_r || out_ready)
  `EG_ASSERT_NEXT(a_go_leaves_idle, go, !seq_idle)
endmodule

FILE: bench/tb_elgamal_encrypt_decrypt.sv
// Self-checking bench for the ElGamal engine: drives encrypt and decrypt words
// under several key settings and compares every result with a local computation.
// Depends on elg_pkg and the elgamal_encrypt_decrypt top level.
`timescale 1ns / 1ps
module tb_elgamal_encrypt_decrypt;
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  elg_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  elg_pkg::out_word_t out_data;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = elg_pkg::REG_MODULUS;
  logic [31:0]        cfg_wdata = '0;

  elgamal_encrypt_decrypt i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  logic [31:0] key_p = 32'd2147483647;
  logic [31:0] key_g = 32'd7;
  logic [31:0] key_y = 32'd1;
  logic [31:0] key_a = 32'd1;

  elg_pkg::in_word_t  words_to_send[$];
  elg_pkg::out_word_t expected_out_q[$];
  int        mismatches = 0;
  int        words_checked = 0;
  int        encrypts_sent = 0;
  int        decrypts_sent = 0;
  bit        no_idle = 1'b0;

  function automatic logic [63:0] modexp(logic [63:0] b, logic [31:0] e, logic [63:0] p);
    logic [63:0] acc;
    acc = 64'd1 % p;
    b = b % p;
    for (int i = 0; i < 32; i++) begin
      if (e[i]) acc = (acc * b) % p;
      b = (b * b) % p;
    end
    return acc;
  endfunction

  function automatic elg_pkg::out_word_t elgamal_compute(elg_pkg::in_word_t w);
    elg_pkg::out_word_t r;
    logic [63:0] p;
    logic [63:0] s;
    r = '0;
    p = {32'd0, key_p};
    if (p >= 2) begin
      if (elg_pkg::action_t'(w.action) == elg_pkg::ACT_ENCRYPT) begin
        r.first_value  = 32'(modexp({32'd0, key_g}, w.ephemeral_exponent, p));
        r.second_value = 32'((modexp({32'd0, key_y}, w.ephemeral_exponent, p)
                          * ({32'd0, w.message} % p)) % p);
      end else begin
        s = modexp({32'd0, w.cipher_first}, key_a, p);
        r.first_value  = 32'((({32'd0, w.cipher_second} % p)
                          * modexp(s, key_p - 32'd2, p)) % p);
      end
    end
    return r;
  endfunction

  // Driver.
  bit in_took = 1'b0;
  int in_gap = 0;
  always @(posedge clk) in_took <= in_valid && in_ready;

  always @(negedge clk) begin
    logic nv;
    if (rst_n) begin
      nv = in_valid;
      if (in_valid && in_took) nv = 1'b0;
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (words_to_send.size() > 0) begin
          in_data <= words_to_send.pop_front();
          nv = 1'b1;
          in_gap = no_idle ? 0 : $urandom_range(0, 6);
        end
      end
      in_valid <= nv;
    end
  end

  // Receiver stalls.
  bit out_took = 1'b0;
  int out_stall = 0;
  always @(posedge clk) out_took <= out_valid && out_ready;

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_took) begin
        out_stall = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    elg_pkg::out_word_t e;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_out_q.insert(expected_out_q.size(), elgamal_compute(in_data));
        if (elg_pkg::action_t'(in_data.action) == elg_pkg::ACT_ENCRYPT) encrypts_sent++;
        else decrypts_sent++;
      end
      if (out_valid && out_ready) begin
        if (expected_out_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", out_data);
        end else begin
          e = expected_out_q.pop_front();
          words_checked++;
          if (out_data.first_value !== e.first_value ||
              out_data.second_value !== e.second_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch p=%h: expected %h %h, got %h %h", key_p,
                       e.first_value, e.second_value,
                       out_data.first_value, out_data.second_value);
          end
        end
      end
    end
  end

  task automatic wait_idle();
    while (words_to_send.size() > 0 || in_valid || expected_out_q.size() > 0)
      @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(elg_pkg::reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      elg_pkg::REG_MODULUS:    key_p = val;
      elg_pkg::REG_GENERATOR:  key_g = val;
      elg_pkg::REG_PUBLIC_KEY: key_y = val;
      default:                 key_a = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_word(elg_pkg::action_t act, logic [31:0] r, logic [31:0] m,
                          logic [31:0] c1, logic [31:0] c2);
    elg_pkg::in_word_t w;
    w.action = act;
    w.ephemeral_exponent = r;
    w.message = m;
    w.cipher_first = c1;
    w.cipher_second = c2;
    words_to_send.insert(words_to_send.size(), w);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return (key_p > 1) ? $urandom_range(0, key_p - 1) : $urandom;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) begin
      add_word(elg_pkg::action_t'($urandom_range(0, 1)), rand_operand(), rand_operand(),
               rand_operand(), rand_operand());
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Reset keys, then extremes of every field.
    add_word(elg_pkg::ACT_ENCRYPT, 32'd0, 32'd5, 32'd0, 32'd0);
    add_word(elg_pkg::ACT_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF);
    add_word(elg_pkg::ACT_ENCRYPT, 32'd1, 32'd0, 32'd3, 32'd3);
    add_word(elg_pkg::ACT_DECRYPT, 32'd9, 32'd9, 32'd0, 32'd1234);
    add_word(elg_pkg::ACT_DECRYPT, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_word(elg_pkg::ACT_DECRYPT, 32'd1, 32'd1, 32'd2147483647, 32'd77);
    add_word(elg_pkg::ACT_DECRYPT, 32'd1, 32'd1, 32'd12345, 32'd0);
    wait_idle();

    write_reg(elg_pkg::REG_MODULUS, 32'd0);
    add_word(elg_pkg::ACT_ENCRYPT, 32'd3, 32'd4, 32'd5, 32'd6);
    add_word(elg_pkg::ACT_DECRYPT, 32'd3, 32'd4, 32'd5, 32'd6);
    wait_idle();
    write_reg(elg_pkg::REG_MODULUS, 32'd1);
    add_word(elg_pkg::ACT_ENCRYPT, 32'd3, 32'd4, 32'd5, 32'd6);
    add_word(elg_pkg::ACT_DECRYPT, 32'd3, 32'd4, 32'd5, 32'd6);
    wait_idle();
    write_reg(elg_pkg::REG_MODULUS, 32'd2);
    write_reg(elg_pkg::REG_GENERATOR, 32'hFFFF_FFFF);
    add_word(elg_pkg::ACT_ENCRYPT, 32'd3, 32'd3, 32'd0, 32'd0);
    add_word(elg_pkg::ACT_DECRYPT, 32'd0, 32'd0, 32'd1, 32'd3);
    add_word(elg_pkg::ACT_DECRYPT, 32'd0, 32'd0, 32'd2, 32'd3);
    wait_idle();

    write_reg(elg_pkg::REG_MODULUS, 32'hFFFF_FFFB);
    write_reg(elg_pkg::REG_GENERATOR, 32'd0);
    write_reg(elg_pkg::REG_PUBLIC_KEY, 32'hFFFF_FFFF);
    write_reg(elg_pkg::REG_PRIVATE_KEY, 32'd0);
    add_word(elg_pkg::ACT_ENCRYPT, 32'd7, 32'hFFFF_FFFC, 32'd0, 32'd0);
    add_word(elg_pkg::ACT_DECRYPT, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFA);
    add_word(elg_pkg::ACT_DECRYPT, 32'd0, 32'd0, 32'hFFFF_FFFB, 32'd10);
    wait_idle();

    write_reg(elg_pkg::REG_PRIVATE_KEY, 32'hFFFF_FFFF);
    write_reg(elg_pkg::REG_PUBLIC_KEY, 32'd0);
    add_word(elg_pkg::ACT_DECRYPT, 32'd0, 32'd0, 32'd3, 32'd10);
    add_word(elg_pkg::ACT_ENCRYPT, 32'd7, 32'd8, 32'd0, 32'd0);
    wait_idle();

    // Random phases over several key sets.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_reg(elg_pkg::REG_MODULUS, 32'd2147483647);
        1: write_reg(elg_pkg::REG_MODULUS, 32'hFFFF_FFFF);
        2: write_reg(elg_pkg::REG_MODULUS, 32'd257);
        3: write_reg(elg_pkg::REG_MODULUS, 32'hFFFF_FFFB);
        4: write_reg(elg_pkg::REG_MODULUS, 32'd3);
        default: write_reg(elg_pkg::REG_MODULUS, 32'd65521);
      endcase
      write_reg(elg_pkg::REG_GENERATOR, $urandom);
      write_reg(elg_pkg::REG_PUBLIC_KEY, $urandom);
      write_reg(elg_pkg::REG_PRIVATE_KEY, $urandom);
      no_idle = (ph == 2);
      add_random(22);
      wait_idle();
    end

    repeat (200) @(posedge clk);
    $display("Checked %0d result words from %0d encrypt and %0d decrypt words,",
             words_checked, encrypts_sent, decrypts_sent);
    $display("across degenerate, small, prime and composite moduli and extreme keys.");
    if (mismatches == 0 && expected_out_q.size() == 0) begin
      $display("[elgamal_encrypt_decrypt] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_out_q.size());
      $display("[elgamal_encrypt_decrypt] ERROR");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout");
    $display("[elgamal_encrypt_decrypt] ERROR");
    $finish;
  end
endmodule
